// ----- rtl/mexp_pkg.sv -----
package mexp_pkg;

	// Default operand width and register map.
	localparam int unsigned MEXP_WIDTH = 32;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned MODULUS_RESET = 2;

	// Register index of the modulus, taken from the word-address bit.
	localparam logic REG_MODULUS = 1'b0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture an input item and start reducing the base
		logic start_mult;  // start result times base
		logic start_sqr;   // start base times base
		logic dbl;         // accumulator doubling step
		logic add;         // accumulator conditional add step
		logic wr_r;        // write the finished product to the running result
		logic wr_b;        // write the finished product to the base
		logic clr_e0;      // clear the exponent bit just consumed by a multiply
		logic shift_e;     // move on to the next exponent bit
		logic out_load;    // copy the running result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic e_zero;      // no exponent bits left to process
		logic e_lsb;       // current exponent bit
	} status_t;

endpackage

// ----- rtl/mexp_if.sv -----
// Input channel: one base and one exponent per transfer.
interface mexp_in_if #(
	parameter int unsigned WIDTH = mexp_pkg::MEXP_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] base;
	logic [WIDTH-1:0] exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink (input valid, input base, input exponent, output ready);
endinterface

// Output channel: one result per transfer.
interface mexp_out_if #(
	parameter int unsigned WIDTH = mexp_pkg::MEXP_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

// ----- rtl/modular_exponentiation.sv -----
// Computes result = base^exponent mod modulus by right-to-left square-and-multiply.
// The modulus is written over the APB port at byte address 0 and read back
// there; write it only while the block is idle. A zero modulus makes all
// arithmetic wrap modulo 2^WIDTH, and an exponent of zero always yields 1.
// One item is worked on at a time. All products go through one shared
// shift-and-add modular multiplier that does one doubling or one addition per
// cycle. An item is first accepted, and its base is reduced by a multiplication
// by one. Then a decision state runs for each exponent bit up to the highest
// set bit, plus a second one after each multiply. Each set bit brings a
// multiplication of the result by the base, and each bit below the highest set
// bit a squaring of the base. The output register is loaded once the previous
// result has been transferred. A new item is accepted while the previous result
// still waits in the output register.
module modular_exponentiation #(
	parameter int unsigned WIDTH = mexp_pkg::MEXP_WIDTH,
	localparam int unsigned DATA_W = (WIDTH > 32) ? 64 : 32,
	localparam int unsigned ADDR_W = (WIDTH > 32) ? mexp_pkg::PADDR_W + 1 : mexp_pkg::PADDR_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mexp_in_if.sink                       req,
	mexp_out_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready
);

	logic [WIDTH-1:0]  modulus_q;
	mexp_pkg::cmd_t    cmd;
	mexp_pkg::status_t status;
	logic              reg_hit;

	// Configuration register: written on the access cycle of an APB transfer.
	// The register index sits just above the byte offset within one data word.
	assign pready = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1] == mexp_pkg::REG_MODULUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WIDTH'(mexp_pkg::MODULUS_RESET);
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			modulus_q <= pwdata[WIDTH-1:0];
		end
	end

	assign prdata = reg_hit ? DATA_W'(modulus_q) : '0;

	mexp_ctrl #(
		.WIDTH(WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.status(status),
		.cmd(cmd)
	);

	mexp_dp #(
		.WIDTH(WIDTH)
	) u_dp (
		.clk(clk),
		.cmd(cmd),
		.status(status),
		.modulus(modulus_q),
		.base(req.base),
		.exponent(req.exponent),
		.result(rsp.result)
	);

endmodule

// ----- rtl/mexp_dp.sv -----
module mexp_dp #(
	parameter int unsigned WIDTH = mexp_pkg::MEXP_WIDTH
) (
	input  logic               clk,
	input  mexp_pkg::cmd_t     cmd,
	output mexp_pkg::status_t  status,
	input  logic [WIDTH-1:0]   modulus,
	input  logic [WIDTH-1:0]   base,
	input  logic [WIDTH-1:0]   exponent,
	output logic [WIDTH-1:0]   result
);

	logic [WIDTH-1:0] r_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] mb_q;
	logic [WIDTH-1:0] res_q;

	logic [WIDTH:0]   mod_ext;
	logic [WIDTH:0]   sum;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] acc_d;

	// A zero modulus stands for 2^WIDTH, so products simply wrap.
	assign mod_ext = {(modulus == '0), modulus};

	// One step of the interleaved modular multiplier: either double the
	// accumulator or add the multiplicand when the current multiplier bit is set,
	// then subtract the modulus once if the sum reached it.
	always_comb begin
		if (cmd.add) begin
			sum = {1'b0, acc_q} + (mb_q[WIDTH-1] ? {1'b0, a_q} : '0);
		end else begin
			sum = {acc_q, 1'b0};
		end
		diff = sum - mod_ext;
		acc_d = (sum >= mod_ext) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
	end

	// Multiplier operands and accumulator.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= WIDTH'(1);
			mb_q <= base;
			acc_q <= '0;
		end else if (cmd.start_mult) begin
			a_q <= r_q;
			mb_q <= b_q;
			acc_q <= '0;
		end else if (cmd.start_sqr) begin
			a_q <= b_q;
			mb_q <= b_q;
			acc_q <= '0;
		end else if (cmd.dbl) begin
			acc_q <= acc_d;
		end else if (cmd.add) begin
			acc_q <= acc_d;
			mb_q <= {mb_q[WIDTH-2:0], 1'b0};
		end
	end

	// Running result starts at one and takes finished products.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q <= WIDTH'(1);
		end else if (cmd.wr_r) begin
			r_q <= acc_d;
		end
	end

	// Base takes the reduced input, then each square.
	always_ff @(posedge clk) begin
		if (cmd.wr_b) begin
			b_q <= acc_d;
		end
	end

	// Exponent bits are consumed from the least significant end.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q <= exponent;
		end else if (cmd.shift_e) begin
			e_q <= {1'b0, e_q[WIDTH-1:1]};
		end else if (cmd.clr_e0) begin
			e_q[0] <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= r_q;
		end
	end

	assign status.e_zero = (e_q == '0);
	assign status.e_lsb = e_q[0];
	assign result = res_q;

endmodule

// ----- rtl/mexp_ctrl.sv -----
module mexp_ctrl #(
	parameter int unsigned WIDTH = mexp_pkg::MEXP_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mexp_pkg::status_t  status,
	output mexp_pkg::cmd_t     cmd
);

	localparam int unsigned CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RED  = 6'b000010,
		S_BIT  = 6'b000100,
		S_MUL  = 6'b001000,
		S_SQR  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             ph_q;
	logic             out_valid_q;
	logic             running;
	logic             last_step;
	logic             in_fire;
	logic             slot_free;

	assign running = (state_q == S_RED) || (state_q == S_MUL) || (state_q == S_SQR);
	assign last_step = ph_q && (cnt_q == CNT_LAST);
	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.dbl = running && !ph_q;
		cmd.add = running && ph_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_RED;
				end
			end
			S_RED: begin
				if (last_step) begin
					cmd.wr_b = 1'b1;
					state_d = S_BIT;
				end
			end
			S_BIT: begin
				if (status.e_zero) begin
					state_d = S_DONE;
				end else if (status.e_lsb) begin
					cmd.start_mult = 1'b1;
					state_d = S_MUL;
				end else begin
					cmd.start_sqr = 1'b1;
					state_d = S_SQR;
				end
			end
			S_MUL: begin
				if (last_step) begin
					cmd.wr_r = 1'b1;
					cmd.clr_e0 = 1'b1;
					state_d = S_BIT;
				end
			end
			S_SQR: begin
				if (last_step) begin
					cmd.wr_b = 1'b1;
					cmd.shift_e = 1'b1;
					state_d = S_BIT;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, step counter and phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ph_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (running) begin
				ph_q <= !ph_q;
				if (ph_q) begin
					cnt_q <= last_step ? '0 : cnt_q + 1'b1;
				end
			end else begin
				ph_q <= 1'b0;
				cnt_q <= '0;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The output register is only overwritten once its result has gone.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before its transfer");

	// An accepted item always starts with the base reduction.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_RED) && (cnt_q == '0) && !ph_q)
		else $error("accepted item did not start the reduction");

	// Products are written back only at the last add step of a multiplication.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_r || cmd.wr_b) |-> (running && last_step))
		else $error("write-back outside the last multiplier step");

	// Only one destination takes a product.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_r && cmd.wr_b))
		else $error("product written to both result and base");

endmodule
